// ----- hdl/wsba_pkg.sv -----
// wsba_pkg: shared types and constants of the weighted score bound accumulator
// no dependencies
`timescale 1ns / 1ps

package wsba_pkg;

  localparam int unsigned NumListsDefault = 4;
  localparam int unsigned NumListsMax     = 4;

  localparam logic [1:0] MODE_SUM      = 2'd0;
  localparam logic [1:0] MODE_MAX      = 2'd1;
  localparam logic [1:0] MODE_SCALED   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_WEIGHT_0 = 3'd1;
  localparam logic [2:0] REG_WEIGHT_3 = 3'd4;

  localparam logic signed [31:0] WEIGHT_RESET = 32'sd65536;

  localparam int unsigned IN_W  = 200;
  localparam int unsigned OUT_W = 200;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/weighted_score_bound_accumulator.sv -----
// weighted_score_bound_accumulator: top level, sequencer with one shared multiplier
// and one shared bit-serial divider; depends on wsba_pkg
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | action, doc_key, list_index, score, floors
//  out_    | master    | out_tvalid/out_tready| key, raw, final, bounds, spread, flags
//  cfg_    | write     | cfg_we               | mode, weights 0..3
//
//  every item runs one multiply pass and 67 divider steps (one quotient bit per
//  cycle), in every mode, although only the scaled mode uses the quotient
//  start / add / other items: one multiply, then the divider;
//  evaluate items: in addition one multiply per list
//  rst_n synchronous active low clears control state, configuration and document state
//  in_tready is low from acceptance until the result has left the out register;
//  while out_tready is low the result is held and in_tready stays low

module weighted_score_bound_accumulator #(
  parameter int unsigned NUM_LISTS = wsba_pkg::NumListsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], doc_key[33:2], list_index[35:34], partial_score[67:36],
  // floor_0[99:68], floor_1[131:100], floor_2[163:132], floor_3[195:164], zeros
  input  logic [wsba_pkg::IN_W-1:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // doc_key_out[31:0], raw_score[63:32], final_score[95:64], lower_bound[127:96],
  // upper_bound[159:128], bound_spread[191:160], duplicate_list[192],
  // divide_error[193], zeros
  output logic [wsba_pkg::OUT_W-1:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned NumListsAll = wsba_pkg::NumListsMax;
  localparam int unsigned OUT_W_L = wsba_pkg::OUT_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ADD  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_DIVS = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0]         mode_r;
  logic signed [31:0] weight_r [NumListsAll];

  // document state
  logic [31:0]        key_r;
  logic [3:0]         mask_r;
  logic signed [31:0] acc_r;
  logic [2:0]         pcnt_r;

  // latched item
  logic [1:0]         act_r;
  logic [1:0]         idx_r;
  logic signed [31:0] part_r;
  logic signed [31:0] floor_r [NumListsAll];

  // working registers
  logic [2:0]         li_r;       // list counter during bounds
  logic signed [63:0] prod_r;     // registered multiplier output
  logic               prod_v_r;
  logic signed [63:0] neg_r, pos_r, high_r;
  logic               dup_r, err_r;
  logic signed [63:0] fin_r;
  logic [66:0]        dividend_r; // magnitude, shifted out msb first
  logic [66:0]        quo_r;
  logic [2:0]         rem_r;
  logic [6:0]         dcnt_r;
  logic               dneg_r;
  logic [OUT_W_L-1:0] out_r;
  logic               out_load_r; // first out cycle, out register still loading

  logic [1:0] mode_act;
  assign mode_act = (mode_r == wsba_pkg::MODE_RESERVED) ? wsba_pkg::MODE_SUM : mode_r;

  // positive-weight count (weights >= 0)
  logic [2:0] npos;
  always_comb begin
    npos = '0;
    for (int i = 0; i < NumListsAll; i++) begin
      if (i < NUM_LISTS && !weight_r[i][31]) npos = npos + 3'd1;
    end
  end

  // shared multiplier: operand select, result floored by arithmetic shift
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    if (state_r == ST_ADD) begin
      mul_a = weight_r[idx_r];
      mul_b = part_r;
    end else begin
      mul_a = floor_r[li_r[1:0]];
      mul_b = weight_r[li_r[1:0]];
    end
    mul_p = (mul_a * mul_b) >>> 16;
  end

  logic signed [31:0] part_sat;
  assign part_sat = wsba_pkg::sat32(prod_r);

  // divider step: 3-bit divisor, restoring
  logic [3:0] rem_sh;
  logic       rem_ge;
  assign rem_sh = {rem_r, dividend_r[66]};
  assign rem_ge = rem_sh >= {1'b0, npos};

  logic signed [66:0] sprod;
  logic signed [63:0] quo_s;
  assign quo_s = dneg_r ? -$signed(quo_r[63:0]) : $signed(quo_r[63:0]);

  logic signed [63:0] lower_w, upper_w, spread_w;
  always_comb begin
    lower_w = '0;
    upper_w = '0;
    if (act_r == wsba_pkg::ACT_EVAL) begin
      unique case (mode_act)
        wsba_pkg::MODE_MAX: begin
          lower_w = 64'(acc_r);
          upper_w = 64'(wsba_pkg::sat32((high_r > 64'(acc_r)) ? high_r : 64'(acc_r)));
        end
        wsba_pkg::MODE_SCALED: begin
          lower_w = fin_r;
          upper_w = 64'(wsba_pkg::sat32(2 * 64'(acc_r) + pos_r - fin_r));
        end
        default: begin
          lower_w = 64'(wsba_pkg::sat32(64'(acc_r) + neg_r));
          upper_w = 64'(wsba_pkg::sat32(64'(acc_r) + pos_r));
        end
      endcase
    end
    spread_w = 64'(wsba_pkg::sat32(upper_w - lower_w));
  end
  assign sprod = 67'(acc_r) * $signed({1'b0, pcnt_r});

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT) && !out_load_r;
  assign out_tdata  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_MUL;
      ST_MUL:  if (prod_v_r && li_r == 3'(NUM_LISTS)) state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == 7'd0) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_tready && !out_load_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= wsba_pkg::MODE_SUM;
      for (int i = 0; i < NumListsAll; i++) weight_r[i] <= wsba_pkg::WEIGHT_RESET;
      key_r    <= '0;
      mask_r   <= '0;
      acc_r    <= '0;
      pcnt_r   <= '0;
      prod_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == wsba_pkg::REG_MODE) mode_r <= cfg_data[1:0];
        else if (cfg_index >= wsba_pkg::REG_WEIGHT_0 && cfg_index <= wsba_pkg::REG_WEIGHT_3)
          weight_r[2'(cfg_index - wsba_pkg::REG_WEIGHT_0)] <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          act_r  <= in_tdata[1:0];
          idx_r  <= in_tdata[35:34];
          part_r <= in_tdata[67:36];
          for (int i = 0; i < NumListsAll; i++) floor_r[i] <= in_tdata[68+32*i +: 32];
          dup_r <= 1'b0;
          if (in_tvalid && in_tdata[1:0] == wsba_pkg::ACT_START) begin
            key_r  <= in_tdata[33:2];
            mask_r <= '0;
            acc_r  <= '0;
            pcnt_r <= '0;
          end
        end
        ST_ADD: begin
          // weighted part of an add item, registered
          prod_r   <= mul_p;
          prod_v_r <= 1'b0;
          li_r     <= '0;
          neg_r    <= '0;
          pos_r    <= '0;
          high_r   <= '0;
        end
        ST_MUL: begin
          if (!prod_v_r) begin
            // first cycle: fold the add item in
            if (act_r == wsba_pkg::ACT_ADD && 32'(idx_r) < NUM_LISTS) begin
              if (mask_r[idx_r]) begin
                dup_r <= 1'b1;
              end else begin
                mask_r[idx_r] <= 1'b1;
                if (mode_act == wsba_pkg::MODE_MAX) begin
                  if (part_sat > acc_r) acc_r <= part_sat;
                end else begin
                  if (mode_act == wsba_pkg::MODE_SCALED && part_sat >= 32'sd1)
                    pcnt_r <= pcnt_r + 3'd1;
                  acc_r <= wsba_pkg::sat32(64'(acc_r) + 64'(part_sat));
                end
              end
            end
            if (act_r == wsba_pkg::ACT_EVAL) begin
              prod_r   <= mul_p;
              prod_v_r <= 1'b1;
              li_r     <= 3'd1;
            end else begin
              prod_v_r <= 1'b1;
              li_r     <= 3'(NUM_LISTS);
            end
          end else if (act_r == wsba_pkg::ACT_EVAL) begin
            // accumulate term of list li_r-1, start next multiply if one remains
            if (!mask_r[li_r[1:0] - 2'd1] && weight_r[li_r[1:0] - 2'd1][31])
              neg_r <= neg_r + prod_r;
            if (!mask_r[li_r[1:0] - 2'd1] && !weight_r[li_r[1:0] - 2'd1][31] &&
                weight_r[li_r[1:0] - 2'd1] != 32'sd0)
              pos_r <= pos_r + prod_r;
            if (prod_r > high_r) high_r <= prod_r;
            if (li_r != 3'(NUM_LISTS)) begin
              prod_r <= mul_p;
              li_r   <= li_r + 3'd1;
            end else begin
              prod_v_r <= 1'b0;
            end
          end else begin
            prod_v_r <= 1'b0;
          end
        end
        ST_DIVS: begin
          dneg_r     <= sprod[66];
          dividend_r <= sprod[66] ? 67'(-sprod) : 67'(sprod);
          quo_r      <= '0;
          rem_r      <= '0;
          dcnt_r     <= 7'd67;
        end
        ST_DIV: begin
          if (dcnt_r != 7'd0) begin
            dividend_r <= {dividend_r[65:0], 1'b0};
            quo_r      <= {quo_r[65:0], rem_ge};
            rem_r      <= rem_ge ? 3'(rem_sh - {1'b0, npos}) : rem_sh[2:0];
            dcnt_r     <= dcnt_r - 7'd1;
          end
        end
        ST_FIN: begin
          err_r <= 1'b0;
          fin_r <= 64'(acc_r);
          if (mode_act == wsba_pkg::MODE_SCALED) begin
            if (npos == 3'd0) begin
              err_r <= 1'b1;
              fin_r <= '0;
            end else if (quo_r[66:64] != 3'd0) begin
              fin_r <= dneg_r ? -64'sd2147483648 : 64'sd2147483647;
            end else begin
              fin_r <= 64'(wsba_pkg::sat32(quo_s));
            end
          end
        end
        ST_OUT: begin
        end
        default: begin
        end
      endcase
      if (state_r == ST_FIN) prod_v_r <= 1'b0;
    end
  end

  // output register loaded after the final score is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_load_r <= 1'b0;
    end else begin
      out_load_r <= (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_r) begin
      out_r <= {6'd0, err_r, dup_r, spread_w[31:0], upper_w[31:0], lower_w[31:0],
                fin_r[31:0], acc_r, key_r};
    end
  end

endmodule
